// ----- rtl/bca_pkg.sv -----
// bca_pkg: shared types, codes and defaults for the chunk allocator
// no dependencies; used by the interfaces, engine, output stage and top level

package bca_pkg;

    localparam int NUM_CHUNKS_DEF = 256;
    localparam int SIZE_W         = 21;
    localparam int OFF_W          = 20;
    localparam int CNT_W          = 9;
    localparam int ID_W           = 8;
    localparam int SHIFT_W        = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd4;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_ROOM   = 2'd1,
        STAT_BAD_FREE  = 2'd2,
        STAT_ZERO_SIZE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_LEFT_RD,
        ST_RIGHT_RD,
        ST_PICK,
        ST_FILL,
        ST_FREE_ID,
        ST_FREE_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_req_type         req_type;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  offset_bytes;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] alloc_offset;
        logic [CNT_W-1:0] chunk_count;
    } t_rsp;

endpackage

// ----- rtl/bca_req_if.sv -----
// bca_req_if: request channel, valid/ready with allocate and free fields
// depends on bca_pkg for field widths

interface bca_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [bca_pkg::SIZE_W-1:0]   size_bytes;
    logic [bca_pkg::OFF_W-1:0]    offset_bytes;

    modport source (output valid, req_type, size_bytes, offset_bytes, input ready);
    modport sink   (input valid, req_type, size_bytes, offset_bytes, output ready);
endinterface

// ----- rtl/bca_rsp_if.sv -----
// bca_rsp_if: response channel, valid/ready with status, offset and count
// depends on bca_pkg for field widths

interface bca_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [bca_pkg::OFF_W-1:0]    alloc_offset;
    logic [bca_pkg::CNT_W-1:0]    chunk_count;

    modport source (output valid, status, alloc_offset, chunk_count, input ready);
    modport sink   (input valid, status, alloc_offset, chunk_count, output ready);
endinterface

// ----- rtl/bitmap_chunk_allocator_top.sv -----
// bitmap_chunk_allocator_top: next-fit chunk allocator over a byte-id map in ram
// depends on bca_pkg, bca_req_if, bca_rsp_if, bca_ram, bca_engine, bca_ostage
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    req_type, size_bytes, offset_bytes
//   o_rsp     out  valid/ready    status, alloc_offset, chunk_count
//   i_cfg_*   in   write enable   chunk_shift (4 bits)
//
// allocate: accept, check, one map read per scan position (at most NUM_CHUNKS + run
//   length - 1), left and right neighbor reads, id pick, one write per chunk, result
// free: accept, check, one read-modify-write per chunk, then one read past the run unless
//   it ends at the last chunk; zero size, no room by count and out-of-range free go from the check to the result
// after reset a clearing pass writes zero to every map entry, no item taken
// a result waits in the output register; the engine holds the next until it frees up

module bitmap_chunk_allocator_top #(
    parameter int NUM_CHUNKS = bca_pkg::NUM_CHUNKS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bca_pkg::SHIFT_W-1:0]  i_cfg_wdata,
    bca_req_if.sink                      i_req,
    bca_rsp_if.source                    o_rsp
);

    import bca_pkg::*;

    localparam int CW = $clog2(NUM_CHUNKS);

    t_req             w_req;
    t_rsp             w_res;
    logic             w_res_valid;
    logic             w_res_ready;
    logic             w_mem_we;
    logic [CW-1:0]    w_mem_waddr;
    logic [ID_W-1:0]  w_mem_wdata;
    logic [CW-1:0]    w_mem_raddr;
    logic [ID_W-1:0]  w_mem_rdata;

    assign w_req.req_type     = t_req_type'(i_req.req_type);
    assign w_req.size_bytes   = i_req.size_bytes;
    assign w_req.offset_bytes = i_req.offset_bytes;

    bca_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_CHUNKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bca_engine #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req.valid),
        .i_req       (w_req),
        .o_req_ready (i_req.ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    bca_ostage u_ostage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_res_ready),
        .o_rsp   (o_rsp)
    );

endmodule

// ----- rtl/bca_ram.sv -----
// bca_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bca_engine.sv -----
// bca_engine: allocate/free sequencer, scans and tags the chunk id map
// depends on bca_pkg; drives the ports of one bca_ram holding the map

module bca_engine #(
    parameter int NUM_CHUNKS = bca_pkg::NUM_CHUNKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bca_pkg::SHIFT_W-1:0]         i_cfg_wdata,
    input  logic                                i_req_valid,
    input  bca_pkg::t_req                       i_req,
    output logic                                o_req_ready,
    output logic                                o_res_valid,
    output bca_pkg::t_rsp                       o_res,
    input  logic                                i_res_ready,
    output logic                                o_mem_we,
    output logic [$clog2(NUM_CHUNKS)-1:0]       o_mem_waddr,
    output logic [bca_pkg::ID_W-1:0]            o_mem_wdata,
    output logic [$clog2(NUM_CHUNKS)-1:0]       o_mem_raddr,
    input  logic [bca_pkg::ID_W-1:0]            i_mem_rdata
);

    import bca_pkg::*;

    localparam int CW = $clog2(NUM_CHUNKS);
    localparam int UW = $clog2(NUM_CHUNKS + 1);
    localparam logic [CW-1:0]    LAST   = CW'(NUM_CHUNKS - 1);
    localparam logic [UW-1:0]    NUM_U  = UW'(NUM_CHUNKS);
    localparam logic [CW:0]      NUM_X  = (CW+1)'(NUM_CHUNKS);
    localparam logic [OFF_W-1:0] NUM_O  = OFF_W'(NUM_CHUNKS);

    function automatic logic [ID_W-1:0] pick_id(input logic [ID_W-1:0] left,
                                                input logic [ID_W-1:0] right);
        logic [ID_W-1:0] c;
        c = left + ID_W'(1);
        if (c == '0 || c == right) begin
            c = c + ID_W'(1);
        end
        if (c == '0 || c == right) begin
            c = c + ID_W'(1);
        end
        return c;
    endfunction

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    t_rsp                r_res, n_res;
    logic [SHIFT_W-1:0]  r_shift, n_shift;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_start, n_start;
    logic [CW-1:0]       r_x, n_x;
    logic [UW-1:0]       r_used, n_used;
    logic [UW-1:0]       r_need, n_need;
    logic [UW-1:0]       r_run, n_run;
    logic [UW-1:0]       r_cnt, n_cnt;
    logic                r_wrap, n_wrap;
    logic [ID_W-1:0]     r_left, n_left;
    logic [ID_W-1:0]     r_id, n_id;

    logic [SHIFT_W-1:0]  sh;
    logic [SIZE_W:0]     mask_w;
    logic [SIZE_W:0]     need_w;
    logic [UW-1:0]       free_cnt;
    logic [OFF_W-1:0]    bi;
    logic                is_free;
    logic [UW-1:0]       run_new;
    logic [CW-1:0]       pos_inc;
    logic [CW-1:0]       x_found;
    logic [CW:0]         right_idx;
    logic                right_in;
    logic                chk_zero, chk_room, chk_bad;
    logic                scan_fail2, scan_found, scan_end, scan_wrap;
    logic                free_match, free_end;
    logic                fill_last;
    logic [UW-1:0]       done_cnt;
    logic [31:0]         off_w;
    logic [31:0]         need32, done32;

    assign sh         = (r_shift > SHIFT_MAX) ? SHIFT_MAX : r_shift;
    assign mask_w     = ((SIZE_W+1)'(1) << sh) - (SIZE_W+1)'(1);
    assign need_w     = ({1'b0, r_req.size_bytes} + mask_w) >> sh;
    assign free_cnt   = NUM_U - r_used;
    assign bi         = r_req.offset_bytes >> sh;
    assign is_free    = (i_mem_rdata == '0);
    assign run_new    = is_free ? r_run + UW'(1) : '0;
    assign pos_inc    = (r_pos == LAST) ? '0 : r_pos + CW'(1);
    assign x_found    = r_pos - CW'(r_need - UW'(1));
    assign right_idx  = {1'b0, r_x} + (CW+1)'(r_need);
    assign right_in   = right_idx < NUM_X;

    assign chk_zero   = (r_req.size_bytes == '0);
    assign chk_room   = need_w > (SIZE_W+1)'(free_cnt);
    assign chk_bad    = bi >= NUM_O;

    // a second-pass run must begin below the scan start
    assign scan_fail2 = r_wrap && (r_pos >= r_start) && (r_run == '0 || !is_free);
    assign scan_found = !scan_fail2 && is_free && (run_new == r_need);
    assign scan_end   = (r_pos == LAST);
    assign scan_wrap  = scan_end && !r_wrap && (r_start != '0);

    assign free_match = (r_state == ST_FREE_ID) ? !is_free : (i_mem_rdata == r_id);
    assign free_end   = free_match && (r_pos == LAST);
    assign done_cnt   = free_match ? r_cnt + UW'(1) : r_cnt;

    assign fill_last  = (r_cnt + UW'(1) == r_need);

    assign off_w      = 32'(r_x) << sh;
    assign need32     = 32'(r_need);
    assign done32     = 32'(done_cnt);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_pos == LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_req.req_type == REQ_ALLOC) begin
                    n_state = (chk_zero || chk_room) ? ST_DONE : ST_SCAN;
                end else begin
                    n_state = chk_bad ? ST_DONE : ST_FREE_ID;
                end
            end
            ST_SCAN: begin
                priority if (scan_fail2) begin
                    n_state = ST_DONE;
                end else if (scan_found) begin
                    n_state = ST_LEFT_RD;
                end else if (scan_end && !scan_wrap) begin
                    n_state = ST_DONE;
                end
            end
            ST_LEFT_RD:  n_state = ST_RIGHT_RD;
            ST_RIGHT_RD: n_state = ST_PICK;
            ST_PICK:     n_state = ST_FILL;
            ST_FILL: begin
                if (fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE_ID: begin
                if (!free_match || free_end) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FREE_RUN;
                end
            end
            ST_FREE_RUN: begin
                if (!free_match || free_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_req_ready = (r_state == ST_IDLE);
        o_res_valid = (r_state == ST_DONE);
        o_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = '0;
        o_mem_raddr = r_pos;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we = 1'b1;
            end
            ST_CHECK: begin
                o_mem_raddr = (r_req.req_type == REQ_ALLOC) ? r_start : bi[CW-1:0];
            end
            ST_SCAN: begin
                o_mem_raddr = pos_inc;
            end
            ST_LEFT_RD: begin
                o_mem_raddr = r_x - CW'(1);
            end
            ST_RIGHT_RD: begin
                o_mem_raddr = right_idx[CW-1:0];
            end
            ST_FILL: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = r_id;
            end
            ST_FREE_ID, ST_FREE_RUN: begin
                o_mem_we    = free_match;
                o_mem_raddr = pos_inc;
            end
            ST_IDLE, ST_PICK, ST_DONE: begin
                o_mem_we = 1'b0;
            end
            default: o_mem_we = 1'b0;
        endcase
    end

    always_comb begin
        n_req   = r_req;
        n_res   = r_res;
        n_pos   = r_pos;
        n_start = r_start;
        n_x     = r_x;
        n_used  = r_used;
        n_need  = r_need;
        n_run   = r_run;
        n_cnt   = r_cnt;
        n_wrap  = r_wrap;
        n_left  = r_left;
        n_id    = r_id;
        n_shift = i_cfg_we ? i_cfg_wdata : r_shift;
        unique case (r_state)
            ST_CLEAR: begin
                n_pos = pos_inc;
            end
            ST_IDLE: begin
                n_req = i_req;
            end
            ST_CHECK: begin
                n_res = '{status: STAT_OK, alloc_offset: '0, chunk_count: '0};
                n_run  = '0;
                n_wrap = 1'b0;
                n_cnt  = '0;
                n_need = UW'(need_w);
                if (r_req.req_type == REQ_ALLOC) begin
                    n_pos = r_start;
                    if (chk_zero) begin
                        n_res.status = STAT_ZERO_SIZE;
                    end else if (chk_room) begin
                        n_res.status = STAT_NO_ROOM;
                    end
                end else begin
                    n_pos = bi[CW-1:0];
                    if (chk_bad) begin
                        n_res.status = STAT_BAD_FREE;
                    end
                end
            end
            ST_SCAN: begin
                n_pos  = pos_inc;
                n_run  = scan_wrap ? '0 : run_new;
                n_wrap = r_wrap | scan_wrap;
                n_x    = x_found;
                if (scan_fail2 || (!scan_found && scan_end && !scan_wrap)) begin
                    n_res.status = STAT_NO_ROOM;
                end
            end
            ST_RIGHT_RD: begin
                n_left = (r_x == '0) ? '0 : i_mem_rdata;
            end
            ST_PICK: begin
                n_id  = pick_id(r_left, right_in ? i_mem_rdata : '0);
                n_pos = r_x;
                n_cnt = '0;
            end
            ST_FILL: begin
                n_pos = pos_inc;
                n_cnt = r_cnt + UW'(1);
                if (fill_last) begin
                    n_start = pos_inc;
                    n_used  = r_used + r_need;
                    n_res   = '{status: STAT_OK, alloc_offset: off_w[OFF_W-1:0],
                                chunk_count: need32[CNT_W-1:0]};
                end
            end
            ST_FREE_ID, ST_FREE_RUN: begin
                if (r_state == ST_FREE_ID) begin
                    n_id = i_mem_rdata;
                end
                if (free_match) begin
                    n_pos = pos_inc;
                    n_cnt = r_cnt + UW'(1);
                end
                if (r_state == ST_FREE_ID && !free_match) begin
                    n_res.status = STAT_BAD_FREE;
                end else if (!free_match || free_end) begin
                    n_used = r_used - done_cnt;
                    n_res  = '{status: STAT_OK, alloc_offset: '0,
                               chunk_count: done32[CNT_W-1:0]};
                end
            end
            ST_LEFT_RD, ST_DONE: begin
                n_cnt = r_cnt;
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pos   <= '0;
            r_start <= '0;
            r_used  <= '0;
            r_shift <= SHIFT_RST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_used  <= n_used;
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_x    <= n_x;
        r_need <= n_need;
        r_run  <= n_run;
        r_cnt  <= n_cnt;
        r_wrap <= n_wrap;
        r_left <= n_left;
        r_id   <= n_id;
    end

endmodule

// ----- rtl/bca_ostage.sv -----
// bca_ostage: one-entry output register in front of the response channel
// depends on bca_pkg and bca_rsp_if

module bca_ostage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bca_pkg::t_rsp    i_data,
    output logic             o_ready,
    bca_rsp_if.source        o_rsp
);

    import bca_pkg::*;

    logic r_valid, n_valid;
    t_rsp r_data, n_data;

    assign o_ready = !r_valid || o_rsp.ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (o_ready) begin
            n_valid = i_valid;
            n_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_data.status;
    assign o_rsp.alloc_offset = r_data.alloc_offset;
    assign o_rsp.chunk_count  = r_data.chunk_count;

endmodule

// ----- tb/sv/bca_alloc_checker.sv -----
`timescale 1ns / 1ps
// bca_alloc_checker: keeps its own copy of the chunk map, works out each response
// and compares it with the one the allocator returns
// depends on bca_pkg, bca_req_if and bca_rsp_if; watches both channels and the config port

module bca_alloc_checker #(
    parameter int NUM_CHUNKS = bca_pkg::NUM_CHUNKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bca_pkg::SHIFT_W-1:0] i_cfg_wdata,
    bca_req_if                          i_req,
    bca_rsp_if                          i_rsp,
    output int unsigned                 o_errors,
    output int unsigned                 o_owed,
    output int unsigned                 o_checked,
    output int unsigned                 o_rejects,
    output logic                        o_hint_valid,
    output logic [bca_pkg::OFF_W-1:0]   o_hint_offset
);

    import bca_pkg::*;

    logic [ID_W-1:0]    id_map [NUM_CHUNKS];
    int unsigned        last_end;
    int unsigned        used_cnt;
    logic [SHIFT_W-1:0] shift_q;
    t_rsp               rsp_owed_q [$];
    int unsigned        err_cnt;
    int unsigned        chk_cnt;
    int unsigned        rej_cnt;

    function automatic int unsigned chunk_log2();
        return (shift_q > SHIFT_MAX) ? 32'(SHIFT_MAX) : 32'(shift_q);
    endfunction

    function automatic t_rsp make_rsp(t_status st, int unsigned off, int unsigned cnt);
        t_rsp r;
        r.status       = st;
        r.alloc_offset = OFF_W'(off);
        r.chunk_count  = CNT_W'(cnt);
        return r;
    endfunction

    function automatic t_rsp alloc_outcome(logic [SIZE_W-1:0] size);
        int unsigned     sh;
        int unsigned     need;
        int unsigned     avail;
        int unsigned     start;
        int unsigned     x;
        int unsigned     y;
        logic [ID_W-1:0] left;
        logic [ID_W-1:0] right;
        logic [ID_W-1:0] tag;
        sh = chunk_log2();
        if (size == '0) begin
            return make_rsp(STAT_ZERO_SIZE, 0, 0);
        end
        need  = (32'(size) + (32'd1 << sh) - 32'd1) >> sh;
        avail = (used_cnt >= NUM_CHUNKS) ? 0 : NUM_CHUNKS - used_cnt;
        if (need > avail) begin
            return make_rsp(STAT_NO_ROOM, 0, 0);
        end
        start = (last_end + 1) % NUM_CHUNKS;
        for (int i = 0; i < NUM_CHUNKS; i++) begin
            x = (start + i) % NUM_CHUNKS;
            y = 0;
            while (y < need && x + y < NUM_CHUNKS && id_map[x + y] == '0) begin
                y++;
            end
            if (y == need) begin
                left  = (x > 0) ? id_map[x - 1] : '0;
                right = (x + need < NUM_CHUNKS) ? id_map[x + need] : '0;
                tag   = left + 8'd1;
                while (tag == right || tag == '0) begin
                    tag = tag + 8'd1;
                end
                for (int z = 0; z < need; z++) begin
                    id_map[x + z] = tag;
                end
                last_end = (x + need - 1) % NUM_CHUNKS;
                used_cnt += need;
                return make_rsp(STAT_OK, x << sh, need);
            end
        end
        return make_rsp(STAT_NO_ROOM, 0, 0);
    endfunction

    function automatic t_rsp free_outcome(logic [OFF_W-1:0] off);
        int unsigned     idx;
        int unsigned     x;
        logic [ID_W-1:0] tag;
        idx = 32'(off) >> chunk_log2();
        if (idx >= NUM_CHUNKS) begin
            return make_rsp(STAT_BAD_FREE, 0, 0);
        end
        tag = id_map[idx];
        if (tag == '0) begin
            return make_rsp(STAT_BAD_FREE, 0, 0);
        end
        x = idx;
        while (x < NUM_CHUNKS && id_map[x] == tag) begin
            id_map[x] = '0;
            x++;
        end
        used_cnt = (used_cnt >= x - idx) ? used_cnt - (x - idx) : 0;
        return make_rsp(STAT_OK, 0, x - idx);
    endfunction

    always @(posedge i_clk) begin
        t_rsp        got;
        t_rsp        want;
        int unsigned c;
        bit          hit;
        if (!i_rst_n) begin
            foreach (id_map[k]) begin
                id_map[k] = '0;
            end
            last_end = NUM_CHUNKS - 1;
            used_cnt = 0;
            shift_q  = SHIFT_RST;
            rsp_owed_q.delete();
            err_cnt  = 0;
            chk_cnt  = 0;
            rej_cnt  = 0;
            o_hint_valid  <= 1'b0;
            o_hint_offset <= '0;
        end else begin
            if (i_cfg_we) begin
                shift_q = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.status       = t_status'(i_rsp.status);
                got.alloc_offset = i_rsp.alloc_offset;
                got.chunk_count  = i_rsp.chunk_count;
                if (rsp_owed_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("unexpected response: status %0d offset %0d count %0d",
                                 got.status, got.alloc_offset, got.chunk_count);
                    end
                end else begin
                    want = rsp_owed_q.pop_front();
                    chk_cnt++;
                    if (want.status != STAT_OK) begin
                        rej_cnt++;
                    end
                    if (got.status !== want.status || got.alloc_offset !== want.alloc_offset ||
                        got.chunk_count !== want.chunk_count) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch on response %0d: want status %0d offset %0d count %0d",
                                     chk_cnt, want.status, want.alloc_offset, want.chunk_count);
                            $display("    got status %0d offset %0d count %0d",
                                     got.status, got.alloc_offset, got.chunk_count);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (t_req_type'(i_req.req_type) == REQ_ALLOC) begin
                    rsp_owed_q.push_back(alloc_outcome(i_req.size_bytes));
                end else begin
                    rsp_owed_q.push_back(free_outcome(i_req.offset_bytes));
                end
                // offer the start of some live run for the next free
                hit = 1'b0;
                c   = $urandom_range(NUM_CHUNKS - 1, 0);
                for (int i = 0; i < NUM_CHUNKS && !hit; i++) begin
                    if (id_map[c] != '0 && (c == 0 || id_map[c - 1] != id_map[c])) begin
                        hit = 1'b1;
                    end else begin
                        c = (c + 1) % NUM_CHUNKS;
                    end
                end
                o_hint_valid  <= hit;
                o_hint_offset <= OFF_W'(c << chunk_log2());
            end
        end
        o_errors  <= err_cnt;
        o_owed    <= rsp_owed_q.size();
        o_checked <= chk_cnt;
        o_rejects <= rej_cnt;
    end

endmodule

// ----- tb/sv/bitmap_chunk_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// bitmap_chunk_allocator_top_tb: drives allocate and free items with random idling on
// both channels, steps the chunk size, and gives the verdict from the checker's counts
// depends on bca_pkg, bca_req_if, bca_rsp_if, bca_alloc_checker and the allocator top level

module bitmap_chunk_allocator_top_tb;
    import bca_pkg::*;

    localparam int     NUM_CHUNKS  = NUM_CHUNKS_DEF;
    localparam int     PHASE_ITEMS = 147;
    // about 1100 items, the limit covers the worst case for each of them four times over
    localparam longint CYCLE_LIMIT = 4_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [SHIFT_W-1:0] cfg_wdata;

    bca_req_if req_ch ();
    bca_rsp_if rsp_ch ();

    int unsigned        errors;
    int unsigned        owed;
    int unsigned        checked;
    int unsigned        rejects;
    logic               hint_valid;
    logic [OFF_W-1:0]   hint_offset;

    logic [SHIFT_W-1:0] shift_now;
    bit                 steady;
    int unsigned        rx_stall;
    int unsigned        items_sent;
    longint             cycles = 0;
    logic [SHIFT_W-1:0] phase_shift [7] = '{4'd0, 4'd12, 4'd15, 4'd4, 4'd1, 4'd13, 4'd7};

    bitmap_chunk_allocator_top #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    bca_alloc_checker #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_errors     (errors),
        .o_owed       (owed),
        .o_checked    (checked),
        .o_rejects    (rejects),
        .o_hint_valid (hint_valid),
        .o_hint_offset(hint_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still owed", cycles, owed);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            return $urandom_range(3, 1);
        end
        if (r < 95) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(70, 30);
    endfunction

    function automatic int unsigned eff_shift();
        return (shift_now > SHIFT_MAX) ? 32'(SHIFT_MAX) : 32'(shift_now);
    endfunction

    function automatic logic [SIZE_W-1:0] size_for(int unsigned nch, int unsigned sh);
        return SIZE_W'(((nch - 1) << sh) + $urandom_range(32'd1 << sh, 1));
    endfunction

    initial begin
        rsp_ch.ready <= 1'b0;
        rx_stall = 0;
        forever begin
            @(posedge i_clk);
            if (rx_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                rx_stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!steady && $urandom_range(99, 0) < 15) begin
                    rx_stall = idle_len();
                end
            end
        end
    end

    task automatic send_item(t_req_type kind, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.size_bytes   <= size;
        req_ch.offset_bytes <= off;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if (!steady && $urandom_range(99, 0) >= 55) begin
            req_ch.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        shift_now = v;
    endtask

    task automatic free_live_item();
        int unsigned      sh;
        logic [OFF_W-1:0] off;
        sh  = eff_shift();
        off = hint_valid ? hint_offset : OFF_W'($urandom_range(NUM_CHUNKS - 1, 0) << sh);
        off = off + OFF_W'($urandom_range((32'd1 << sh) - 1, 0));
        if ($urandom_range(99, 0) < 20) begin
            off = off + OFF_W'($urandom_range(2, 1) << sh);
        end
        send_item(REQ_FREE, SIZE_W'($urandom), off);
    endtask

    task automatic random_item();
        int unsigned r;
        int unsigned sh;
        int unsigned nch;
        sh = eff_shift();
        r  = $urandom_range(99, 0);
        if (r < 45) begin
            r = $urandom_range(99, 0);
            nch = (r < 70) ? $urandom_range(8, 1) :
                  (r < 92) ? $urandom_range(64, 9) : $urandom_range(NUM_CHUNKS, 65);
            send_item(REQ_ALLOC, size_for(nch, sh), OFF_W'($urandom));
        end else if (r < 80) begin
            free_live_item();
        end else if (r < 88) begin
            send_item(REQ_FREE, SIZE_W'($urandom),
                      OFF_W'(($urandom_range(NUM_CHUNKS - 1, 0) << sh) +
                             $urandom_range((32'd1 << sh) - 1, 0)));
        end else if (r < 92) begin
            send_item(REQ_FREE, SIZE_W'($urandom), OFF_W'($urandom));
        end else if (r < 95) begin
            send_item(REQ_ALLOC, '0, OFF_W'($urandom));
        end else begin
            send_item(REQ_ALLOC, SIZE_W'($urandom_range(1048576, 1)), OFF_W'($urandom));
        end
    endtask

    initial begin
        int unsigned n;
        int unsigned k;
        int unsigned r;
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_ALLOC;
        req_ch.size_bytes   <= '0;
        req_ch.offset_bytes <= '0;
        shift_now      = SHIFT_RST;
        steady         = 1'b0;
        items_sent     = 0;
        phase_shift[6] = $urandom_range(11, 2);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // chunk size 16 from reset
        send_item(REQ_ALLOC, 21'd0, '0);
        send_item(REQ_FREE, '0, 20'd0);
        send_item(REQ_FREE, '0, 20'hFFFFF);
        send_item(REQ_ALLOC, 21'd1, '0);
        send_item(REQ_ALLOC, 21'd16, '0);
        send_item(REQ_ALLOC, 21'd17, '0);
        send_item(REQ_ALLOC, 21'd1048576, '0);
        send_item(REQ_FREE, '0, 20'd53);
        send_item(REQ_FREE, '0, 20'd32);
        send_item(REQ_FREE, '0, 20'd32);
        send_item(REQ_ALLOC, 21'd3200, '0);
        send_item(REQ_ALLOC, 21'd864, '0);
        send_item(REQ_ALLOC, 21'd832, '0);
        send_item(REQ_ALLOC, 21'd48, '0);
        send_item(REQ_ALLOC, 21'd32, '0);
        send_item(REQ_ALLOC, 21'd1, '0);
        send_item(REQ_FREE, '0, 20'd4095);
        send_item(REQ_ALLOC, 21'd16, '0);
        send_item(REQ_FREE, '0, 20'd0);
        send_item(REQ_ALLOC, 21'd16, '0);
        send_item(REQ_FREE, '0, 20'd64);
        send_item(REQ_FREE, '0, 20'd3264);
        send_item(REQ_FREE, '0, 20'd32);
        send_item(REQ_FREE, '0, 20'd16);

        foreach (phase_shift[p]) begin
            write_shift(phase_shift[p]);
            steady = (p == 3);
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(99, 0);
                if (r < 3) begin
                    // pack the map with small runs
                    k = $urandom_range(60, 20);
                    repeat (k) send_item(REQ_ALLOC, size_for($urandom_range(2, 1), eff_shift()),
                                         OFF_W'($urandom));
                    n += k;
                end else if (r < 6) begin
                    k = $urandom_range(40, 15);
                    repeat (k) free_live_item();
                    n += k;
                end else if (r < 8) begin
                    drain();
                end else begin
                    random_item();
                    n++;
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        $display("sent %0d items across chunk shifts 0 to 15, checked %0d responses",
                 items_sent, checked);
        $display("%0d responses were rejects, %0d mismatches, %0d still owed",
                 rejects, errors, owed);
        if (errors == 0 && owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- bitmap_chunk_allocator_top.f -----
rtl/bca_pkg.sv
rtl/bca_req_if.sv
rtl/bca_rsp_if.sv
rtl/bca_ram.sv
rtl/bca_engine.sv
rtl/bca_ostage.sv
rtl/bitmap_chunk_allocator_top.sv
tb/sv/bca_alloc_checker.sv
tb/sv/bitmap_chunk_allocator_top_tb.sv
